FILE: rtl/core/mwem_pkg.sv
// Shared types, constants and field layout of the Microwire EEPROM word master.
package mwem_pkg;

  localparam int unsigned WORD_BITS_DEF     = 16;
  localparam int unsigned MAX_ADDR_BITS_DEF = 8;

  localparam int unsigned S_TDATA_W  = 32;
  localparam int unsigned S_TUSER_W  = 2;
  localparam int unsigned M_TDATA_W  = 24;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;

  localparam int unsigned OUT_CS_BIT    = 0;
  localparam int unsigned OUT_SK_BIT    = 1;
  localparam int unsigned OUT_DI_BIT    = 2;
  localparam int unsigned OUT_PRE_BIT   = 3;
  localparam int unsigned OUT_BUSY_BIT  = 4;
  localparam int unsigned OUT_DONE_BIT  = 5;
  localparam int unsigned OUT_RDATA_LSB = 6;
  localparam int unsigned OUT_TERR_BIT  = 22;

  localparam logic [15:0] OP_READ  = 16'hC000;
  localparam logic [15:0] OP_EWEN  = 16'h9800;
  localparam logic [15:0] OP_WRITE = 16'hA000;
  localparam logic [15:0] OP_EWDS  = 16'h8000;

  localparam logic [15:0] POLL_LIMIT_RST    = 16'd200;
  localparam logic [15:0] POLL_INTERVAL_RST = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLL_LIMIT    = 1'b0,
    CFG_POLL_INTERVAL = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    K_IDLE, K_SEL, K_DESEL, K_OUT, K_IN, K_CHECK, K_POLL
  } kind_e;

  typedef enum logic [4:0] {
    PH_IDLE, PR_SEL, PR_CMD, PR_CHECK, PR_EXTRA, PR_DATA, PR_DESEL,
    RD_SEL, RD_CMD, RD_DATA, RD_DESEL,
    EN_SEL, EN_CMD, EN_DESEL,
    WR_SEL, WR_CMD, WR_DATA, WR_DESEL,
    HO_SEL, HO_POLL, HO_DESEL,
    DS_SEL, DS_CMD, DS_DESEL
  } phase_e;

  typedef struct packed {
    logic        req;
    logic        wr;
    logic [7:0]  addr;
    logic [15:0] wdata;
    logic        dout;
  } tick_t;

endpackage

FILE: rtl/core/mwem_front.sv
// Front end: unpacks tick requests and queues them for the sequencer.
module mwem_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  // word_address[7:0], write_data[23:8], serial_data_out[24], zero fill
  input  logic [mwem_pkg::S_TDATA_W-1:0]   s_tdata_i,
  // request_valid[0], opcode[1]
  input  logic [mwem_pkg::S_TUSER_W-1:0]   s_tuser_i,
  output mwem_pkg::tick_t                  item_o,
  output logic                             item_valid_o,
  input  logic                             item_pop_i
);
  import mwem_pkg::*;

  tick_t              q_q [QDEPTH];
  logic [QPTR_W-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QPTR_W:0]    cnt_q, cnt_d;
  logic               push;
  tick_t              in_tick;

  always_comb begin
    in_tick.req   = s_tuser_i[0];
    in_tick.wr    = s_tuser_i[1];
    in_tick.addr  = s_tdata_i[7:0];
    in_tick.wdata = s_tdata_i[23:8];
    in_tick.dout  = s_tdata_i[24];
  end

  assign s_tready_o   = (cnt_q != (QPTR_W+1)'(QDEPTH));
  assign push         = s_tvalid_i && s_tready_o;
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = q_q[rptr_q];

  always_comb begin
    wptr_d = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = item_pop_i ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(item_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wptr_q] <= in_tick;
    end
  end

endmodule

FILE: rtl/core/mwem_seq.sv
// Back end: Microwire sequencer, configuration registers and result register.
module mwem_seq #(
  parameter int unsigned WORD_BITS     = mwem_pkg::WORD_BITS_DEF,
  parameter int unsigned MAX_ADDR_BITS = mwem_pkg::MAX_ADDR_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mwem_pkg::tick_t                  item_i,
  input  logic                             item_valid_i,
  output logic                             item_pop_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mwem_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mwem_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  output logic [mwem_pkg::M_TDATA_W-1:0]   m_tdata_o
);
  import mwem_pkg::*;

  localparam logic [4:0] CMD_LONG   = 5'(3 + MAX_ADDR_BITS);
  localparam logic [4:0] CMD_SHORT  = 5'd9;
  localparam logic [4:0] EXTRA_BITS = 5'(MAX_ADDR_BITS - 6);
  localparam logic [4:0] WB5        = 5'(WORD_BITS);
  localparam int unsigned LONG_SH   = 13 - MAX_ADDR_BITS;
  localparam int unsigned WD_SH     = 16 - WORD_BITS;
  localparam logic [7:0] LONG_MASK  = 8'((1 << MAX_ADDR_BITS) - 1);
  localparam logic [7:0] SHORT_MASK = 8'h3F;
  localparam logic       LONG_EXTRA = (MAX_ADDR_BITS > 6);

  typedef struct packed {
    phase_e      phase;
    logic [4:0]  bcnt;
    logic [15:0] shw;
    logic [15:0] pollc;
    logic [15:0] intc;
    logic        wfail;
    logic [24:0] pend;
    logic        known;
    logic        longc;
    logic        cs;
    logic        sk;
    logic        di;
    logic        pre;
    logic [15:0] last_rd;
  } st_t;

  localparam st_t ST_RST = '{phase: PH_IDLE, bcnt: 5'd0, shw: 16'd0, pollc: 16'd0,
                             intc: 16'd0, wfail: 1'b0, pend: 25'd0, known: 1'b0,
                             longc: 1'b0, cs: 1'b0, sk: 1'b0, di: 1'b0, pre: 1'b1,
                             last_rd: 16'd0};

  function automatic kind_e kind_of(phase_e p);
    kind_e k;
    unique case (p)
      PR_SEL, RD_SEL, EN_SEL, WR_SEL, HO_SEL, DS_SEL:         k = K_SEL;
      PR_DESEL, RD_DESEL, EN_DESEL, WR_DESEL, HO_DESEL,
      DS_DESEL:                                                k = K_DESEL;
      PR_CMD, PR_EXTRA, RD_CMD, EN_CMD, WR_CMD, WR_DATA,
      DS_CMD:                                                  k = K_OUT;
      PR_DATA, RD_DATA:                                        k = K_IN;
      PR_CHECK:                                                k = K_CHECK;
      HO_POLL:                                                 k = K_POLL;
      default:                                                 k = K_IDLE;
    endcase
    return k;
  endfunction

  function automatic phase_e next_of(phase_e p);
    phase_e n;
    unique case (p)
      PR_SEL:   n = PR_CMD;
      PR_CMD:   n = PR_CHECK;
      PR_CHECK: n = PR_DATA;
      PR_EXTRA: n = PR_DATA;
      PR_DATA:  n = PR_DESEL;
      RD_SEL:   n = RD_CMD;
      RD_CMD:   n = RD_DATA;
      RD_DATA:  n = RD_DESEL;
      EN_SEL:   n = EN_CMD;
      EN_CMD:   n = EN_DESEL;
      EN_DESEL: n = WR_SEL;
      WR_SEL:   n = WR_CMD;
      WR_CMD:   n = WR_DATA;
      WR_DATA:  n = WR_DESEL;
      WR_DESEL: n = HO_SEL;
      HO_SEL:   n = HO_POLL;
      HO_POLL:  n = HO_DESEL;
      HO_DESEL: n = DS_SEL;
      DS_SEL:   n = DS_CMD;
      DS_CMD:   n = DS_DESEL;
      default:  n = PH_IDLE;
    endcase
    return n;
  endfunction

  function automatic logic [15:0] addressed(st_t s, logic [15:0] op);
    logic [7:0]  a8;
    logic [15:0] a16;
    a8  = s.pend[23:16] & (s.longc ? LONG_MASK : SHORT_MASK);
    a16 = {8'h00, a8};
    return op | (s.longc ? (a16 << LONG_SH) : (a16 << 7));
  endfunction

  function automatic phase_e start_ph(st_t s);
    return s.pend[24] ? EN_SEL : RD_SEL;
  endfunction

  function automatic st_t enter(st_t s, phase_e p);
    st_t        r;
    logic [4:0] cmd_bits;
    r        = s;
    cmd_bits = s.longc ? CMD_LONG : CMD_SHORT;
    r.phase  = p;
    r.bcnt   = 5'd0;
    case (p)
      PR_CMD: begin
        r.shw  = OP_READ;
        r.bcnt = CMD_SHORT;
      end
      PR_EXTRA: begin
        r.shw  = 16'd0;
        r.bcnt = EXTRA_BITS;
      end
      RD_CMD: begin
        r.shw  = addressed(s, OP_READ);
        r.bcnt = cmd_bits;
      end
      EN_CMD: begin
        r.shw  = OP_EWEN;
        r.bcnt = cmd_bits;
      end
      WR_CMD: begin
        r.shw  = addressed(s, OP_WRITE);
        r.bcnt = cmd_bits;
      end
      DS_CMD: begin
        r.shw  = OP_EWDS;
        r.bcnt = cmd_bits;
      end
      WR_DATA: begin
        r.shw  = s.pend[15:0] << WD_SH;
        r.bcnt = WB5;
      end
      PR_DATA, RD_DATA: begin
        r.shw = 16'd0;
      end
      HO_POLL: begin
        r.pollc = 16'd0;
        r.intc  = 16'd0;
        r.wfail = 1'b0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  st_t         st_q, st_d;
  logic [15:0] limit_q, interval_q;
  logic        oval_q;
  logic [M_TDATA_W-1:0] odata_q, odata_d;
  logic        fire, done, terr;

  assign fire        = item_valid_i && (!oval_q || m_tready_i);
  assign item_pop_o  = fire;
  assign cfg_ready_o = 1'b1;
  assign m_tvalid_o  = oval_q;
  assign m_tdata_o   = odata_q;

  // next state: one sequencer step per tick
  always_comb begin
    st_t  s;
    logic fin;
    logic fin_in;
    s      = st_q;
    fin    = 1'b0;
    fin_in = 1'b0;
    done   = 1'b0;
    terr   = 1'b0;
    if (s.phase == PH_IDLE && item_i.req) begin
      s.pend = {item_i.wr, item_i.addr, item_i.wdata};
      s      = enter(s, s.known ? start_ph(s) : PR_SEL);
    end
    unique case (kind_of(s.phase))
      K_SEL: begin
        if (s.bcnt == 5'd0) begin
          s.sk   = 1'b0;
          s.di   = 1'b0;
          s.pre  = 1'b0;
          s.bcnt = 5'd1;
        end else if (s.bcnt == 5'd1) begin
          s.cs   = 1'b1;
          s.bcnt = 5'd2;
        end else begin
          s.sk = 1'b1;
          fin  = 1'b1;
        end
      end
      K_DESEL: begin
        if (s.bcnt == 5'd0) begin
          s.sk   = 1'b0;
          s.di   = 1'b0;
          s.bcnt = 5'd1;
        end else if (s.bcnt == 5'd1) begin
          s.cs   = 1'b0;
          s.pre  = 1'b1;
          s.bcnt = 5'd2;
        end else begin
          s.sk = 1'b1;
          if (s.phase == DS_DESEL) begin
            terr = s.wfail;
          end
          fin = 1'b1;
        end
      end
      K_OUT: begin
        if (s.sk) begin
          s.di = s.shw[15];
          s.sk = 1'b0;
        end else begin
          s.sk  = 1'b1;
          s.shw = {s.shw[14:0], 1'b0};
          if (s.bcnt != 5'd0) begin
            s.bcnt = s.bcnt - 5'd1;
          end
          if (s.bcnt == 5'd0) begin
            fin = 1'b1;
          end
        end
      end
      K_IN: begin
        s.di = 1'b0;
        if (s.sk) begin
          s.sk = 1'b0;
          if (s.bcnt != 5'd0) begin
            s.shw = {s.shw[14:0], item_i.dout};
          end
          if (s.bcnt >= WB5) begin
            if (s.phase == RD_DATA) begin
              s.last_rd = s.shw;
            end
            fin    = 1'b1;
            fin_in = 1'b1;
          end
        end else begin
          s.sk   = 1'b1;
          s.bcnt = s.bcnt + 5'd1;
        end
      end
      K_CHECK: begin
        s.di    = 1'b0;
        s.longc = item_i.dout;
        s       = enter(s, (s.longc && LONG_EXTRA) ? PR_EXTRA : PR_DATA);
      end
      K_POLL: begin
        if (s.intc == 16'd0) begin
          if (item_i.dout) begin
            fin = 1'b1;
          end else if (s.pollc >= limit_q) begin
            s.wfail = 1'b1;
            fin     = 1'b1;
          end else begin
            s.pollc = s.pollc + 16'd1;
            s.intc  = (interval_q <= 16'd1) ? 16'd0 : 16'd1;
          end
        end else begin
          s.intc = s.intc + 16'd1;
          if (s.intc >= interval_q) begin
            s.intc = 16'd0;
          end
        end
      end
      default: begin
      end
    endcase
    if (fin) begin
      if (s.phase == PR_DESEL) begin
        s.known = 1'b1;
        s       = enter(s, start_ph(s));
      end else if (s.phase == RD_DESEL || s.phase == DS_DESEL) begin
        s    = enter(s, PH_IDLE);
        done = 1'b1;
      end else begin
        s = enter(s, next_of(s.phase));
      end
      if (fin_in) begin
        s.bcnt = 5'd1;
      end
    end
    st_d = s;
  end

  // outputs: pin levels and status of this tick
  always_comb begin
    odata_d                                   = '0;
    odata_d[OUT_CS_BIT]                       = st_d.cs;
    odata_d[OUT_SK_BIT]                       = st_d.sk;
    odata_d[OUT_DI_BIT]                       = st_d.di;
    odata_d[OUT_PRE_BIT]                      = st_d.pre;
    odata_d[OUT_BUSY_BIT]                     = (st_d.phase != PH_IDLE);
    odata_d[OUT_DONE_BIT]                     = done;
    odata_d[OUT_RDATA_LSB +: 16]              = st_d.last_rd;
    odata_d[OUT_TERR_BIT]                     = done && terr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_RST;
      oval_q     <= 1'b0;
      limit_q    <= POLL_LIMIT_RST;
      interval_q <= POLL_INTERVAL_RST;
    end else begin
      if (fire) begin
        st_q <= st_d;
      end
      if (fire) begin
        oval_q <= 1'b1;
      end else if (m_tready_i) begin
        oval_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_POLL_LIMIT:    limit_q    <= cfg_data_i;
          CFG_POLL_INTERVAL: interval_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      odata_q <= odata_d;
    end
  end

endmodule

FILE: rtl/core/microwire_eeprom_word_master_top.sv
// Top level of the Microwire EEPROM word master: request queue plus sequencer.
//
// Each accepted input item is one serial half-clock tick and yields exactly one result
// item with the pin levels and status of that tick. The sequencer takes one step per
// clock while the result register is free or being taken, so the block then sustains
// one item per cycle; an item passes through the two-entry request queue and then the
// result register, which holds the result until it is taken. While a result is not taken
// the queue fills and the input stalls. The first request after reset runs a width probe
// before its own sequence. Configuration writes are always taken on the spot.
module microwire_eeprom_word_master_top #(
  parameter int unsigned WORD_BITS     = mwem_pkg::WORD_BITS_DEF,
  parameter int unsigned MAX_ADDR_BITS = mwem_pkg::MAX_ADDR_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  // word_address[7:0], write_data[23:8], serial_data_out[24], zero fill [31:25]
  input  logic [mwem_pkg::S_TDATA_W-1:0]   s_tdata_i,
  // request_valid[0], opcode[1]
  input  logic [mwem_pkg::S_TUSER_W-1:0]   s_tuser_i,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  // chip_select[0], serial_clock[1], serial_data_in[2], pre_pin[3], busy_res[4],
  // done_res[5], read_data[21:6], timeout_error[22], zero fill [23]
  output logic [mwem_pkg::M_TDATA_W-1:0]   m_tdata_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mwem_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mwem_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import mwem_pkg::*;

  tick_t item;
  logic  item_valid;
  logic  item_pop;

  mwem_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid_i),
    .s_tready_o   (s_tready_o),
    .s_tdata_i    (s_tdata_i),
    .s_tuser_i    (s_tuser_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  mwem_seq #(
    .WORD_BITS     (WORD_BITS),
    .MAX_ADDR_BITS (MAX_ADDR_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .m_tvalid_o   (m_tvalid_o),
    .m_tready_i   (m_tready_i),
    .m_tdata_o    (m_tdata_o)
  );

endmodule

FILE: rtl/core/mwem_chk.sv
// Port-level checks for the Microwire EEPROM word master and their bind.
module mwem_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_tvalid_o,
  input logic                             m_tready_i,
  input logic [mwem_pkg::M_TDATA_W-1:0]   m_tdata_o
);
  import mwem_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("result changed while stalled");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[OUT_DONE_BIT] |-> !m_tdata_o[OUT_BUSY_BIT])
    else $error("done reported while busy");

  a_timeout_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[OUT_TERR_BIT] |-> m_tdata_o[OUT_DONE_BIT])
    else $error("timeout without done");

  a_cs_pre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[OUT_CS_BIT] |-> !m_tdata_o[OUT_PRE_BIT])
    else $error("PRE high while selected");

  a_idle_deselected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tdata_o[OUT_BUSY_BIT] |-> !m_tdata_o[OUT_CS_BIT])
    else $error("chip selected while idle");

endmodule

bind microwire_eeprom_word_master_top mwem_chk u_mwem_chk (.*);

FILE: tb/mwem_pin_checker.sv
`timescale 1ns / 100ps
// Checker of the Microwire EEPROM word master: tick-accurate pin and status prediction.
module mwem_pin_checker
  import mwem_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [S_TDATA_W-1:0]  s_tdata_i,
  input  logic [S_TUSER_W-1:0]  s_tuser_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [M_TDATA_W-1:0]  m_tdata_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    mismatches_o,
  output int                    results_o,
  output int                    waiting_o
);

  logic [M_TDATA_W-1:0] expected_pins[$];
  logic [M_TDATA_W-1:0] want;

  phase_e      ph;
  logic [4:0]  bcnt;
  logic [15:0] shw;
  logic        wknown;
  logic        lcmd;
  logic [15:0] pcnt;
  logic [15:0] icnt;
  logic        p_wr;
  logic [7:0]  p_addr;
  logic [15:0] p_wdata;
  logic        cs, sk, di, pre;
  logic [15:0] rword;
  logic        wfail;
  logic [15:0] poll_limit;
  logic [15:0] poll_interval;

  task automatic check_field(string what, int unsigned got, int unsigned exp_val);
    if (got !== exp_val) begin
      $display("result %0d: %s is %0h, expected %0h", results_o, what, got, exp_val);
      mismatches_o++;
    end
  endtask

  function automatic int addr_width();
    return lcmd ? int'(MAX_ADDR_BITS_DEF) : 6;
  endfunction

  function automatic logic [15:0] with_address(logic [15:0] op);
    int          ab;
    logic [15:0] a;
    ab = addr_width();
    a  = 16'(p_addr) & 16'((1 << ab) - 1);
    return op | (a << (13 - ab));
  endfunction

  function automatic kind_e kind_of(phase_e p);
    case (p)
      PR_SEL, RD_SEL, EN_SEL, WR_SEL, HO_SEL, DS_SEL: return K_SEL;
      PR_DESEL, RD_DESEL, EN_DESEL, WR_DESEL, HO_DESEL, DS_DESEL: return K_DESEL;
      PR_CMD, PR_EXTRA, RD_CMD, EN_CMD, WR_CMD, WR_DATA, DS_CMD: return K_OUT;
      PR_DATA, RD_DATA: return K_IN;
      PR_CHECK: return K_CHECK;
      HO_POLL: return K_POLL;
      default: return K_IDLE;
    endcase
  endfunction

  function automatic phase_e first_phase();
    return p_wr ? EN_SEL : RD_SEL;
  endfunction

  function automatic void enter_phase(phase_e p);
    ph   = p;
    bcnt = '0;
    case (p)
      PR_CMD: begin
        shw  = OP_READ;
        bcnt = 5'd9;
      end
      PR_EXTRA: begin
        shw  = '0;
        bcnt = 5'(MAX_ADDR_BITS_DEF - 6);
      end
      RD_CMD: begin
        shw  = with_address(OP_READ);
        bcnt = 5'(3 + addr_width());
      end
      EN_CMD: begin
        shw  = OP_EWEN;
        bcnt = 5'(3 + addr_width());
      end
      WR_CMD: begin
        shw  = with_address(OP_WRITE);
        bcnt = 5'(3 + addr_width());
      end
      DS_CMD: begin
        shw  = OP_EWDS;
        bcnt = 5'(3 + addr_width());
      end
      WR_DATA: begin
        shw  = p_wdata;
        bcnt = 5'(WORD_BITS_DEF);
      end
      PR_DATA, RD_DATA: shw = '0;
      HO_POLL: begin
        pcnt  = '0;
        icnt  = '0;
        wfail = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // A finished phase hands on to the next in enum order, except at the end of the probe and of a sequence.
  function automatic logic finish_phase();
    if (ph == PR_DESEL) begin
      wknown = 1'b1;
      enter_phase(first_phase());
      return 1'b0;
    end
    if (ph == RD_DESEL || ph == DS_DESEL) begin
      enter_phase(PH_IDLE);
      return 1'b1;
    end
    enter_phase(phase_e'(ph + 1));
    return 1'b0;
  endfunction

  function automatic logic [M_TDATA_W-1:0] predict_pins(logic req, logic wr, logic [7:0] addr,
                                                        logic [15:0] wdata, logic dout);
    logic                 done;
    logic                 terr;
    logic [M_TDATA_W-1:0] word;
    done = 1'b0;
    terr = 1'b0;
    if (ph == PH_IDLE && req) begin
      p_wr    = wr;
      p_addr  = addr;
      p_wdata = wdata;
      enter_phase(wknown ? first_phase() : PR_SEL);
    end
    case (kind_of(ph))
      K_SEL: begin
        if (bcnt == 0) begin
          sk   = 1'b0;
          di   = 1'b0;
          pre  = 1'b0;
          bcnt = 5'd1;
        end else if (bcnt == 1) begin
          cs   = 1'b1;
          bcnt = 5'd2;
        end else begin
          sk   = 1'b1;
          done = finish_phase();
        end
      end
      K_DESEL: begin
        if (bcnt == 0) begin
          sk   = 1'b0;
          di   = 1'b0;
          bcnt = 5'd1;
        end else if (bcnt == 1) begin
          cs   = 1'b0;
          pre  = 1'b1;
          bcnt = 5'd2;
        end else begin
          sk = 1'b1;
          if (ph == DS_DESEL) terr = wfail;
          done = finish_phase();
        end
      end
      K_OUT: begin
        if (sk) begin
          di = shw[15];
          sk = 1'b0;
        end else begin
          sk  = 1'b1;
          shw = shw << 1;
          if (bcnt > 0) bcnt = bcnt - 5'd1;
          if (bcnt == 0) done = finish_phase();
        end
      end
      K_IN: begin
        di = 1'b0;
        if (sk) begin
          sk = 1'b0;
          if (bcnt > 0) shw = {shw[14:0], dout};
          if (bcnt >= WORD_BITS_DEF) begin
            if (ph == RD_DATA) rword = shw;
            done = finish_phase();
            bcnt = 5'd1;
          end
        end else begin
          sk   = 1'b1;
          bcnt = bcnt + 5'd1;
        end
      end
      K_CHECK: begin
        di   = 1'b0;
        lcmd = dout;
        enter_phase((lcmd && MAX_ADDR_BITS_DEF > 6) ? PR_EXTRA : PR_DATA);
      end
      K_POLL: begin
        if (icnt == 0) begin
          if (dout) begin
            done = finish_phase();
          end else if (pcnt >= poll_limit) begin
            wfail = 1'b1;
            done  = finish_phase();
          end else begin
            pcnt = pcnt + 16'd1;
            icnt = (poll_interval <= 16'd1) ? 16'd0 : 16'd1;
          end
        end else begin
          icnt = icnt + 16'd1;
          if (icnt >= poll_interval) icnt = '0;
        end
      end
      default: ;
    endcase
    word                         = '0;
    word[OUT_CS_BIT]             = cs;
    word[OUT_SK_BIT]             = sk;
    word[OUT_DI_BIT]             = di;
    word[OUT_PRE_BIT]            = pre;
    word[OUT_BUSY_BIT]           = (ph != PH_IDLE);
    word[OUT_DONE_BIT]           = done;
    word[OUT_RDATA_LSB +: 16]    = rword;
    word[OUT_TERR_BIT]           = done & terr;
    return word;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph            = PH_IDLE;
      bcnt          = '0;
      shw           = '0;
      wknown        = 1'b0;
      lcmd          = 1'b0;
      pcnt          = '0;
      icnt          = '0;
      p_wr          = 1'b0;
      p_addr        = '0;
      p_wdata       = '0;
      cs            = 1'b0;
      sk            = 1'b0;
      di            = 1'b0;
      pre           = 1'b1;
      rword         = '0;
      wfail         = 1'b0;
      poll_limit    = POLL_LIMIT_RST;
      poll_interval = POLL_INTERVAL_RST;
      mismatches_o  = 0;
      results_o     = 0;
      waiting_o     = 0;
      expected_pins.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_POLL_LIMIT:    poll_limit = cfg_data_i;
          CFG_POLL_INTERVAL: poll_interval = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_pins.push_back(predict_pins(s_tuser_i[0], s_tuser_i[1], s_tdata_i[7:0],
                                             s_tdata_i[23:8], s_tdata_i[24]));
      end
      if (m_tvalid_i && m_tready_i) begin
        if (expected_pins.size() == 0) begin
          check_field("unexpected result", 1, 0);
        end else begin
          want = expected_pins.pop_front();
          check_field("chip_select", m_tdata_i[OUT_CS_BIT], want[OUT_CS_BIT]);
          check_field("serial_clock", m_tdata_i[OUT_SK_BIT], want[OUT_SK_BIT]);
          check_field("serial_data_in", m_tdata_i[OUT_DI_BIT], want[OUT_DI_BIT]);
          check_field("pre_pin", m_tdata_i[OUT_PRE_BIT], want[OUT_PRE_BIT]);
          check_field("busy", m_tdata_i[OUT_BUSY_BIT], want[OUT_BUSY_BIT]);
          check_field("done", m_tdata_i[OUT_DONE_BIT], want[OUT_DONE_BIT]);
          check_field("read_data", m_tdata_i[OUT_RDATA_LSB +: 16],
                      want[OUT_RDATA_LSB +: 16]);
          check_field("timeout_error", m_tdata_i[OUT_TERR_BIT], want[OUT_TERR_BIT]);
          check_field("fill", m_tdata_i[M_TDATA_W-1], 0);
        end
        results_o++;
      end
      waiting_o = expected_pins.size();
    end
  end

endmodule

FILE: tb/microwire_eeprom_word_master_top_tb.sv
`timescale 1ns / 100ps
// Testbench top of the Microwire EEPROM word master: tick stimulus, register writes, verdict.
module microwire_eeprom_word_master_top_tb;
  import mwem_pkg::*;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  s_tvalid_i  = 1'b0;
  logic                  s_tready_o;
  logic [S_TDATA_W-1:0]  s_tdata_i   = '0;
  logic [S_TUSER_W-1:0]  s_tuser_i   = '0;
  logic                  m_tvalid_o;
  logic                  m_tready_i  = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  int mismatches;
  int results;
  int waiting;
  int ticks_sent = 0;
  bit calm       = 1'b0;
  bit hold_off   = 1'b0;
  bit held_off   = 1'b0;

  always #5 clk_i = ~clk_i;

  microwire_eeprom_word_master_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  mwem_pin_checker pin_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid_i),
    .s_tready_i   (s_tready_o),
    .s_tdata_i    (s_tdata_i),
    .s_tuser_i    (s_tuser_i),
    .m_tvalid_i   (m_tvalid_o),
    .m_tready_i   (m_tready_i),
    .m_tdata_i    (m_tdata_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .results_o    (results),
    .waiting_o    (waiting)
  );

  task automatic send_tick(bit req, bit wr, logic [7:0] addr, logic [15:0] wdata, bit dout);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {7'd0, dout, wdata, addr};
    s_tuser_i  <= {wr, req};
    do @(posedge clk_i); while (!s_tready_o);
    ticks_sent++;
  endtask

  task automatic random_ticks(int count, int dout_pct);
    repeat (count) begin
      send_tick($urandom_range(0, 99) < 70, $urandom_range(0, 1), 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 65535)), $urandom_range(0, 99) < dout_pct);
    end
  endtask

  // Hold the sender until every tick has come back.
  task automatic drain();
    s_tvalid_i <= 1'b0;
    wait (results >= ticks_sent);
    @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off && !held_off) begin
        m_tready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        held_off = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        m_tready_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first request at reset settings, then requests offered while busy
    for (int i = 0; i < 16; i++) begin
      send_tick(1'b1, i[0], (i % 4 < 2) ? 8'hFF : 8'h00, (i % 4 < 2) ? 16'h0000 : 16'hFFFF,
                i[1] ^ i[2]);
    end
    random_ticks(134, 75);
    drain();

    write_reg(CFG_POLL_LIMIT, 16'd0);
    write_reg(CFG_POLL_INTERVAL, 16'd0);
    random_ticks(150, 20);
    drain();

    write_reg(CFG_POLL_LIMIT, 16'd3);
    write_reg(CFG_POLL_INTERVAL, 16'd2);
    random_ticks(150, 10);
    drain();

    write_reg(CFG_POLL_LIMIT, 16'hFFFF);
    write_reg(CFG_POLL_INTERVAL, 16'd1);
    hold_off = 1'b1;
    random_ticks(150, 50);
    drain();

    // DO stuck high keeps the longest interval from stretching the run
    write_reg(CFG_POLL_LIMIT, 16'd1);
    write_reg(CFG_POLL_INTERVAL, 16'hFFFF);
    random_ticks(100, 100);
    drain();

    calm = 1'b1;
    write_reg(CFG_POLL_LIMIT, 16'd200);
    write_reg(CFG_POLL_INTERVAL, 16'd3);
    random_ticks(150, 60);
    drain();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && waiting == 0) begin
      $display("microwire_eeprom_word_master_top test passed");
    end else begin
      $display("microwire_eeprom_word_master_top test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("microwire_eeprom_word_master_top test failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/mwem_pkg.sv
rtl/core/mwem_front.sv
rtl/core/mwem_seq.sv
rtl/core/microwire_eeprom_word_master_top.sv
rtl/core/mwem_chk.sv
tb/mwem_pin_checker.sv
tb/microwire_eeprom_word_master_top_tb.sv
